>>> rtl/workspace_polygon_point_gate_assert.svh
// assertion macros for the polygon point gate
// used by the top level, expects clk and rst_n in scope
`ifndef WORKSPACE_POLYGON_POINT_GATE_ASSERT_SVH
`define WORKSPACE_POLYGON_POINT_GATE_ASSERT_SVH

// same-cycle implication
`define PPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ppg_pkg.sv
// shared types, constants and helpers of the polygon point gate
// no dependencies
`timescale 1ns / 1ps

package ppg_pkg;

  localparam int VERTEX_DEPTH = 128;
  localparam int COORD_WIDTH  = 32;

  localparam int IN_COORD_W  = 32;
  localparam int IN_TDATA_W  = 2 * IN_COORD_W;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 3;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int MARKER_W    = 8;
  localparam int VHELD_W     = 8;

  localparam int CNT_W  = $clog2(VERTEX_DEPTH + 1);
  localparam int ADDR_W = $clog2(VERTEX_DEPTH);
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int LO_W   = DIFF_W / 2;
  localparam int HI_W   = DIFF_W - LO_W;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int WIDE_W = PROD_W + 1;

  localparam logic [MARKER_W-1:0] MARKER_LIMIT_RESET = MARKER_W'(100);

  typedef enum logic [OUT_TUSER_W-1:0] {
    ST_PLACED  = 3'd0,
    ST_OUTSIDE = 3'd1,
    ST_LIMIT   = 3'd2,
    ST_CLOSED  = 3'd3,
    ST_NOCLOSE = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_AREA_COMPLETE = 1'b0,
    REG_MARKER_LIMIT  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic    capture;
    logic    rd_zero;
    logic    scan_clear;
    logic    scan_rd;
    logic    wr_item;
    logic    wr_copy;
    logic    inc_marker;
    logic    load_out;
    status_t out_code;
    logic    out_inside;
  } ppg_cmd_t;

  typedef struct packed {
    logic limit_hit;
    logic kind;
    logic area_complete;
    logic vcount_zero;
    logic vcount_full;
    logic scan_last;
    logic pipe_busy;
    logic in_poly;
    logic out_free;
  } ppg_stat_t;

  // low coordinate bits, sign-extended to the internal width
  function automatic logic signed [COORD_WIDTH-1:0] coord_ext(
      input logic [IN_COORD_W-1:0] v);
    logic signed [COORD_WIDTH-1:0] r;
    for (int k = 0; k < COORD_WIDTH; k++) begin
      r[k] = v[(k < IN_COORD_W) ? k : IN_COORD_W - 1];
    end
    return r;
  endfunction

  function automatic logic [DIFF_W-1:0] mag_of(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] r;
    r = v[DIFF_W-1] ? (~v) + DIFF_W'(1) : v;
    return r;
  endfunction

endpackage

>>> rtl/ppg_ctrl.sv
// controller state machine of the polygon point gate
// depends on ppg_pkg, drives the datapath by command struct
`timescale 1ns / 1ps

module ppg_ctrl import ppg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ppg_stat_t stat,
  output ppg_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DECIDE   = 6'b000010,
    S_CLOSE_WR = 6'b000100,
    S_SCAN     = 6'b001000,
    S_DRAIN    = 6'b010000,
    S_FINISH   = 6'b100000
  } state_t;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;
  logic    inside_r, inside_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r   <= code_nxt;
    inside_r <= inside_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    code_nxt       = code_r;
    inside_nxt     = inside_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.out_code   = code_r;
    cmd.out_inside = inside_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        inside_nxt = 1'b0;
        state_nxt  = S_FINISH;
        priority if (stat.limit_hit) begin
          code_nxt = ST_LIMIT;
        end else if (!stat.kind && !stat.area_complete) begin
          code_nxt       = ST_PLACED;
          cmd.inc_marker = 1'b1;
        end else if (!stat.kind && stat.vcount_zero) begin
          code_nxt = ST_OUTSIDE;
        end else if (!stat.kind) begin
          cmd.scan_clear = 1'b1;
          state_nxt      = S_SCAN;
        end else if (stat.vcount_full) begin
          code_nxt = ST_FULL;
        end else if (!stat.area_complete) begin
          code_nxt       = ST_PLACED;
          cmd.wr_item    = 1'b1;
          cmd.inc_marker = 1'b1;
        end else if (stat.vcount_zero) begin
          code_nxt = ST_NOCLOSE;
        end else begin
          cmd.rd_zero = 1'b1;
          state_nxt   = S_CLOSE_WR;
        end
      end
      S_CLOSE_WR: begin
        cmd.wr_copy = 1'b1;
        code_nxt    = ST_CLOSED;
        state_nxt   = S_FINISH;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          inside_nxt     = stat.in_poly;
          code_nxt       = stat.in_poly ? ST_PLACED : ST_OUTSIDE;
          cmd.inc_marker = stat.in_poly;
          state_nxt      = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/ppg_datapath.sv
// datapath of the polygon point gate: registers, vertex memory,
// edge crossing pipeline and result register; depends on ppg_pkg
`timescale 1ns / 1ps

module ppg_datapath import ppg_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [IN_TDATA_W-1:0]        in_data,
  input  logic                         in_kind,
  input  logic                         cfg_we,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  ppg_cmd_t                     cmd,
  output ppg_stat_t                    stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [OUT_TDATA_W-1:0]       out_data,
  output logic [OUT_TUSER_W-1:0]       out_user
);

  // configuration and counters
  logic                area_r;
  logic [MARKER_W-1:0] limit_r;
  logic [MARKER_W-1:0] marker_r;
  logic [CNT_W-1:0]    vcount_r;
  logic [CNT_W-1:0]    scan_k_r;

  // current item
  logic                          kind_r;
  logic signed [COORD_WIDTH-1:0] px_r, py_r;

  // vertex memory
  logic signed [COORD_WIDTH-1:0] mem_x_r [VERTEX_DEPTH];
  logic signed [COORD_WIDTH-1:0] mem_y_r [VERTEX_DEPTH];
  logic signed [COORD_WIDTH-1:0] rd_x_r, rd_y_r;
  logic signed [COORD_WIDTH-1:0] wr_x, wr_y;
  logic [ADDR_W-1:0]             rd_addr, wr_addr;
  logic [CNT_W-1:0]              scan_idx;
  logic                          rd_en, wr_en;
  logic                          rd_valid_r, rd_first_r;

  // edge pipeline
  logic signed [COORD_WIDTH-1:0] vj_x_r, vj_y_r;
  logic signed [DIFF_W-1:0]      da, dd, db, de;
  logic                          straddle;
  logic                          e_v_r;
  logic signed [DIFF_W-1:0]      da_r, dd_r, db_r, de_r;
  logic [DIFF_W-1:0]             ma, md, mb, me;
  logic                          m_v_r, m_dpos_r, m_lneg_r, m_rneg_r;
  logic [2*LO_W-1:0]             l_ll_r, r_ll_r;
  logic [LO_W+HI_W-1:0]          l_lh_r, l_hl_r, r_lh_r, r_hl_r;
  logic [2*HI_W-1:0]             l_hh_r, r_hh_r;
  logic [PROD_W-1:0]             lmag, rmag;
  logic signed [WIDE_W-1:0]      lsv, rsv;
  logic                          s_v_r, s_dpos_r;
  logic signed [WIDE_W-1:0]      lhs_r, rhs_r;
  logic                          crosses;
  logic                          inside_r;

  // result register
  logic                 out_valid_r;
  status_t              out_code_r;
  logic                 out_inside_r;
  logic [MARKER_W-1:0]  out_marker_r;
  logic [VHELD_W-1:0]   out_vert_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r  <= 1'b0;
      limit_r <= MARKER_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_AREA_COMPLETE: area_r  <= cfg_wdata[0];
        REG_MARKER_LIMIT:  limit_r <= cfg_wdata[MARKER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      px_r   <= coord_ext(in_data[IN_COORD_W-1:0]);
      py_r   <= coord_ext(in_data[IN_TDATA_W-1:IN_COORD_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= '0;
      vcount_r <= '0;
      scan_k_r <= '0;
    end else begin
      if (cmd.inc_marker) begin
        marker_r <= marker_r + MARKER_W'(1);
      end
      if (wr_en) begin
        vcount_r <= vcount_r + CNT_W'(1);
      end
      if (cmd.scan_clear) begin
        scan_k_r <= '0;
      end else if (cmd.scan_rd) begin
        scan_k_r <= scan_k_r + CNT_W'(1);
      end
    end
  end

  // scan order: last vertex first, then vertices from the start
  assign scan_idx = (scan_k_r == '0) ? vcount_r - CNT_W'(1) : scan_k_r - CNT_W'(1);
  assign rd_addr  = cmd.rd_zero ? '0 : scan_idx[ADDR_W-1:0];
  assign rd_en    = cmd.rd_zero | cmd.scan_rd;
  assign wr_en    = cmd.wr_item | cmd.wr_copy;
  assign wr_addr  = vcount_r[ADDR_W-1:0];
  assign wr_x     = cmd.wr_copy ? rd_x_r : px_r;
  assign wr_y     = cmd.wr_copy ? rd_y_r : py_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x_r[wr_addr] <= wr_x;
      mem_y_r[wr_addr] <= wr_y;
    end
    if (rd_en) begin
      rd_x_r <= mem_x_r[rd_addr];
      rd_y_r <= mem_y_r[rd_addr];
    end
  end

  // edge stage
  assign straddle = (rd_y_r >= py_r) != (vj_y_r >= py_r);
  assign da = $signed({px_r[COORD_WIDTH-1], px_r}) - $signed({rd_x_r[COORD_WIDTH-1], rd_x_r});
  assign dd = $signed({vj_y_r[COORD_WIDTH-1], vj_y_r}) - $signed({rd_y_r[COORD_WIDTH-1], rd_y_r});
  assign db = $signed({vj_x_r[COORD_WIDTH-1], vj_x_r}) - $signed({rd_x_r[COORD_WIDTH-1], rd_x_r});
  assign de = $signed({py_r[COORD_WIDTH-1], py_r}) - $signed({rd_y_r[COORD_WIDTH-1], rd_y_r});

  always_ff @(posedge clk) begin
    if (rd_valid_r) begin
      vj_x_r <= rd_x_r;
      vj_y_r <= rd_y_r;
    end
    da_r <= da;
    dd_r <= dd;
    db_r <= db;
    de_r <= de;
  end

  // product stage, split into partial products
  assign ma = mag_of(da_r);
  assign md = mag_of(dd_r);
  assign mb = mag_of(db_r);
  assign me = mag_of(de_r);

  always_ff @(posedge clk) begin
    m_dpos_r <= !dd_r[DIFF_W-1];
    m_lneg_r <= da_r[DIFF_W-1] ^ dd_r[DIFF_W-1];
    m_rneg_r <= db_r[DIFF_W-1] ^ de_r[DIFF_W-1];
    l_ll_r   <= ma[LO_W-1:0] * md[LO_W-1:0];
    l_lh_r   <= ma[LO_W-1:0] * md[DIFF_W-1:LO_W];
    l_hl_r   <= ma[DIFF_W-1:LO_W] * md[LO_W-1:0];
    l_hh_r   <= ma[DIFF_W-1:LO_W] * md[DIFF_W-1:LO_W];
    r_ll_r   <= mb[LO_W-1:0] * me[LO_W-1:0];
    r_lh_r   <= mb[LO_W-1:0] * me[DIFF_W-1:LO_W];
    r_hl_r   <= mb[DIFF_W-1:LO_W] * me[LO_W-1:0];
    r_hh_r   <= mb[DIFF_W-1:LO_W] * me[DIFF_W-1:LO_W];
  end

  // sum stage
  assign lmag = PROD_W'(l_ll_r) + (PROD_W'(l_lh_r) << LO_W) + (PROD_W'(l_hl_r) << LO_W)
              + (PROD_W'(l_hh_r) << (2 * LO_W));
  assign rmag = PROD_W'(r_ll_r) + (PROD_W'(r_lh_r) << LO_W) + (PROD_W'(r_hl_r) << LO_W)
              + (PROD_W'(r_hh_r) << (2 * LO_W));
  assign lsv  = m_lneg_r ? -$signed({1'b0, lmag}) : $signed({1'b0, lmag});
  assign rsv  = m_rneg_r ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});

  always_ff @(posedge clk) begin
    lhs_r    <= lsv;
    rhs_r    <= rsv;
    s_dpos_r <= m_dpos_r;
  end

  // compare stage
  assign crosses = s_dpos_r ? (lhs_r <= rhs_r) : (lhs_r >= rhs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      rd_first_r <= 1'b0;
      e_v_r      <= 1'b0;
      m_v_r      <= 1'b0;
      s_v_r      <= 1'b0;
      inside_r   <= 1'b0;
    end else begin
      rd_valid_r <= cmd.scan_rd;
      rd_first_r <= cmd.scan_rd && (scan_k_r == '0);
      e_v_r      <= rd_valid_r && !rd_first_r && straddle;
      m_v_r      <= e_v_r;
      s_v_r      <= m_v_r;
      if (cmd.scan_clear) begin
        inside_r <= 1'b0;
      end else if (s_v_r && crosses) begin
        inside_r <= !inside_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_code_r   <= cmd.out_code;
      out_inside_r <= cmd.out_inside;
      out_marker_r <= marker_r;
      out_vert_r   <= VHELD_W'(vcount_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_user  = out_code_r;
  assign out_data  = OUT_TDATA_W'({out_vert_r, out_marker_r, out_inside_r});

  assign stat.limit_hit     = marker_r >= limit_r;
  assign stat.kind          = kind_r;
  assign stat.area_complete = area_r;
  assign stat.vcount_zero   = vcount_r == '0;
  assign stat.vcount_full   = vcount_r >= CNT_W'(VERTEX_DEPTH);
  assign stat.scan_last     = scan_k_r == vcount_r;
  assign stat.pipe_busy     = rd_valid_r | e_v_r | m_v_r | s_v_r;
  assign stat.in_poly       = inside_r;
  assign stat.out_free      = !out_valid_r || out_ready;

endmodule

>>> rtl/workspace_polygon_point_gate.sv
// Polygon point gate: wall clicks build a vertex polygon, path clicks are placed
// freely while the area is open and only when inside it once the area is complete.
// One item is worked at a time. A path point with the area complete walks all n
// stored edges through the vertex memory read port, one edge per cycle into a
// four-stage multiply and compare pipeline. The result sits in an output register,
// so the next item is taken while it waits. The vertex memory needs no clearing
// after reset. Depends on ppg_pkg, ppg_ctrl, ppg_datapath.
`timescale 1ns / 1ps
`include "workspace_polygon_point_gate_assert.svh"

module workspace_polygon_point_gate import ppg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pos_x, pos_y
  input  logic [0:0]             in_tuser,   // kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // inside_res, markers_placed, vertices_held
  output logic [OUT_TUSER_W-1:0] out_tuser,  // status
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  ppg_cmd_t  cmd;
  ppg_stat_t stat;

  ppg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ppg_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .in_kind   (in_tuser[0]),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_user  (out_tuser)
  );

  `PPG_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "item taken while busy")
  `PPG_ASSERT_NOW(a_no_overwrite, cmd.load_out, stat.out_free, "waiting result overwritten")
  `PPG_ASSERT_NOW(a_store_room, cmd.wr_item || cmd.wr_copy, !stat.vcount_full,
                  "vertex written into full store")
  `PPG_ASSERT_NOW(a_scan_idle, cmd.capture, !stat.pipe_busy, "item taken during edge walk")

endmodule

>>> tb/ppg_gate_checker.sv
// result checker for the polygon point gate: tracks register writes and accepted
// clicks, predicts each result and compares it with what leaves the block
// depends on ppg_pkg
`timescale 1ns / 1ps

module ppg_gate_checker import ppg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pos_x, pos_y
  input  logic [0:0]             in_tuser,   // kind
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // inside_res, markers_placed, vertices_held
  input  logic [OUT_TUSER_W-1:0] out_tuser,  // status
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     err_count,
  output int                     pending
);

  typedef struct packed {
    status_t              status;
    logic                 in_poly;
    logic [MARKER_W-1:0]  markers;
    logic [VHELD_W-1:0]   vheld;
  } gate_result_t;

  logic signed [COORD_WIDTH-1:0] vert_x [VERTEX_DEPTH];
  logic signed [COORD_WIDTH-1:0] vert_y [VERTEX_DEPTH];
  int                            vert_cnt = 0;
  int                            mark_cnt = 0;
  logic                          area_done = 1'b0;
  logic [MARKER_W-1:0]           mark_limit = MARKER_LIMIT_RESET;
  gate_result_t                  awaited_results [$];

  logic signed [COORD_WIDTH-1:0] px, py;
  gate_result_t                  want, got;

  initial begin
    err_count = 0;
    pending   = 0;
  end

  // even-odd crossing test over the stored vertex list, exact wide compare
  function automatic logic crossing_inside(input logic signed [COORD_WIDTH-1:0] qx,
                                           input logic signed [COORD_WIDTH-1:0] qy);
    logic              odd;
    logic signed [67:0] dy, lhs, rhs;
    int                i, j;
    odd = 1'b0;
    if (vert_cnt == 0) return 1'b0;
    j = vert_cnt - 1;
    for (i = 0; i < vert_cnt; i++) begin
      if ((vert_y[i] >= qy) != (vert_y[j] >= qy)) begin
        dy  = vert_y[j] - vert_y[i];
        lhs = (qx - vert_x[i]) * dy;
        rhs = (vert_x[j] - vert_x[i]) * (qy - vert_y[i]);
        if (dy > 0 ? (lhs <= rhs) : (lhs >= rhs)) odd = ~odd;
      end
      j = i;
    end
    return odd;
  endfunction

  task automatic check_field(input string what, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      vert_cnt   = 0;
      mark_cnt   = 0;
      area_done  = 1'b0;
      mark_limit = MARKER_LIMIT_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_AREA_COMPLETE: area_done  = cfg_wdata[0];
          REG_MARKER_LIMIT:  mark_limit = cfg_wdata[MARKER_W-1:0];
          default: ;
        endcase
      end

      if (out_tvalid && out_tready) begin
        got.status  = status_t'(out_tuser);
        got.in_poly = out_tdata[0];
        got.markers = out_tdata[MARKER_W:1];
        got.vheld   = out_tdata[MARKER_W+VHELD_W:MARKER_W+1];
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing awaited, got status %0d tdata %h",
                   $time, out_tuser, out_tdata);
          err_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, got.status);
          check_field("inside_res", want.in_poly, got.in_poly);
          check_field("markers_placed", want.markers, got.markers);
          check_field("vertices_held", want.vheld, got.vheld);
          check_field("tdata padding", 0, out_tdata[OUT_TDATA_W-1:MARKER_W+VHELD_W+1]);
        end
      end

      if (in_tvalid && in_tready) begin
        px = in_tdata[IN_COORD_W-1:0];
        py = in_tdata[2*IN_COORD_W-1:IN_COORD_W];
        want.in_poly = 1'b0;
        if (mark_cnt >= int'(mark_limit)) begin
          want.status = ST_LIMIT;
        end else if (!in_tuser[0]) begin
          if (!area_done) begin
            want.status = ST_PLACED;
            mark_cnt++;
          end else if (crossing_inside(px, py)) begin
            want.in_poly = 1'b1;
            want.status  = ST_PLACED;
            mark_cnt++;
          end else begin
            want.status = ST_OUTSIDE;
          end
        end else if (!area_done) begin
          if (vert_cnt >= VERTEX_DEPTH) begin
            want.status = ST_FULL;
          end else begin
            vert_x[vert_cnt] = px;
            vert_y[vert_cnt] = py;
            vert_cnt++;
            mark_cnt++;
            want.status = ST_PLACED;
          end
        end else if (vert_cnt == 0) begin
          want.status = ST_NOCLOSE;
        end else if (vert_cnt >= VERTEX_DEPTH) begin
          want.status = ST_FULL;
        end else begin
          vert_x[vert_cnt] = vert_x[0];
          vert_y[vert_cnt] = vert_y[0];
          vert_cnt++;
          want.status = ST_CLOSED;
        end
        want.markers = MARKER_W'(mark_cnt);
        want.vheld   = VHELD_W'(vert_cnt);
        awaited_results.insert(awaited_results.size(), want);
      end
    end
    pending = awaited_results.size();
  end

endmodule

>>> tb/tb_workspace_polygon_point_gate.sv
// top of the polygon point gate testbench: clock, reset, click stimulus,
// register writes and the verdict; checking lives in ppg_gate_checker
// depends on ppg_pkg, ppg_gate_checker and workspace_polygon_point_gate
`timescale 1ns / 1ps

module tb_workspace_polygon_point_gate;
  import ppg_pkg::*;

  localparam logic [31:0] COORD_MIN = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX = 32'h7fff_ffff;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // pos_x, pos_y
  logic [0:0]             in_tuser = '0;   // kind
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // inside_res, markers_placed, vertices_held
  logic [OUT_TUSER_W-1:0] out_tuser;       // status
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int tx_idle_pct = 23;
  int rx_idle_pct = 46;
  int items_sent = 0;
  int wall_items = 0;
  int reg_writes = 0;
  logic [31:0] seen_x [$];
  logic [31:0] seen_y [$];

  always #5 clk = ~clk;

  workspace_polygon_point_gate u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  ppg_gate_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .err_count(mismatches), .pending(outstanding)
  );

  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic logic [31:0] jitter(input logic [31:0] c, input int bits);
    logic [31:0] m;
    m = (bits >= 32) ? 32'hffff_ffff : (32'd1 << bits) - 32'd1;
    return c + ($urandom() & m) - (m >> 1);
  endfunction

  function automatic int pick_scale();
    int r;
    r = $urandom_range(9);
    if (r < 2) return 6;
    if (r < 5) return 16;
    if (r < 8) return 24;
    return 32;
  endfunction

  task automatic send_item(input logic wall, input logic [31:0] x, input logic [31:0] y);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tuser  <= wall;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (wall) wall_items++;
    if (items_sent == 400) begin
      tx_idle_pct = 46;
      rx_idle_pct = 23;
    end else if (items_sent == 800) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  // hold off the sender until every result is back
  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // walls of a fresh polygon, usually a close, then probe points around it
  task automatic polygon_round(input int probes);
    logic [31:0] cx, cy, vx, vy;
    int          bits, nv, k, pick, sel;
    bits = pick_scale();
    cx   = $urandom();
    cy   = $urandom();
    nv   = $urandom_range(3, 8);
    settle();
    set_reg(REG_AREA_COMPLETE, 8'd0);
    set_reg(REG_MARKER_LIMIT, ($urandom_range(5) == 0) ? 8'($urandom_range(255)) : 8'd255);
    for (k = 0; k < nv; k++) begin
      if (k == 0 || $urandom_range(9) != 0) begin
        vx = jitter(cx, bits);
        vy = jitter(cy, bits);
      end
      seen_x.insert(seen_x.size(), vx);
      seen_y.insert(seen_y.size(), vy);
      if ($urandom_range(7) == 0) send_item(1'b0, jitter(cx, bits), jitter(cy, bits));
      send_item(1'b1, vx, vy);
    end
    settle();
    set_reg(REG_AREA_COMPLETE, 8'd1);
    if ($urandom_range(7) != 0) send_item(1'b1, $urandom(), $urandom());
    for (k = 0; k < probes; k++) begin
      pick = $urandom_range(9);
      sel  = $urandom_range(seen_y.size() - 1);
      if (pick == 0) send_item(1'b0, jitter(seen_x[sel], bits), seen_y[sel]);
      else if (pick == 1) send_item(1'b0, $urandom(), $urandom());
      else if (pick == 2) send_item(1'b1, $urandom(), $urandom());
      else if (pick == 3) send_item(1'b0, jitter(seen_x[sel], bits), jitter(seen_y[sel], bits));
      else send_item(1'b0, jitter(cx, bits), jitter(cy, bits));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store: gated path is outside, close has nothing to copy
    set_reg(REG_AREA_COMPLETE, 8'd1);
    send_item(1'b0, 32'd0, 32'd0);
    send_item(1'b1, $urandom(), $urandom());
    settle();
    set_reg(REG_MARKER_LIMIT, 8'd0);
    send_item(1'b0, $urandom(), $urandom());
    send_item(1'b1, $urandom(), $urandom());
    settle();
    set_reg(REG_MARKER_LIMIT, 8'd255);
    set_reg(REG_AREA_COMPLETE, 8'd0);

    // full-range square with a repeated corner
    send_item(1'b0, COORD_MIN, COORD_MAX);
    send_item(1'b1, COORD_MIN, COORD_MIN);
    send_item(1'b1, COORD_MAX, COORD_MIN);
    send_item(1'b1, COORD_MAX, COORD_MAX);
    send_item(1'b1, COORD_MAX, COORD_MAX);
    send_item(1'b1, COORD_MIN, COORD_MAX);
    settle();
    set_reg(REG_AREA_COMPLETE, 8'd1);
    send_item(1'b1, $urandom(), $urandom());
    send_item(1'b0, 32'd0, 32'd0);
    send_item(1'b0, COORD_MAX, 32'd0);
    send_item(1'b0, COORD_MIN, 32'd0);
    send_item(1'b0, 32'd0, COORD_MIN);
    send_item(1'b0, 32'd0, COORD_MAX);
    send_item(1'b0, COORD_MAX, COORD_MAX);
    send_item(1'b0, COORD_MIN, COORD_MIN);
    send_item(1'b1, $urandom(), $urandom());

    repeat (7) polygon_round(15);

    // fill the store with closes, then overflow it both ways
    settle();
    set_reg(REG_MARKER_LIMIT, 8'd255);
    set_reg(REG_AREA_COMPLETE, 8'd1);
    repeat (140) send_item(1'b1, $urandom(), $urandom());
    settle();
    set_reg(REG_AREA_COMPLETE, 8'd0);
    repeat (4) send_item(1'b1, $urandom(), $urandom());

    while (items_sent < 1200) polygon_round(40);

    settle();
    repeat (20) @(posedge clk);
    $display("covered %0d clicks (%0d wall, %0d path) and %0d register writes,",
             items_sent, wall_items, items_sent - wall_items, reg_writes);
    $display("including an empty store, a full store and marker limits from 0 to 255");
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", outstanding);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/ppg_pkg.sv
rtl/ppg_ctrl.sv
rtl/ppg_datapath.sv
rtl/workspace_polygon_point_gate.sv
tb/ppg_gate_checker.sv
tb/tb_workspace_polygon_point_gate.sv
